[rtl/ndap_pkg.sv]
// Shared constants and types for the named decimal assignment parser.
`default_nettype none

package ndap_pkg;

    localparam int NAME_SLOTS    = 6;
    localparam int NAME_BYTES    = 8;
    localparam int MANTISSA_BITS = 32;

    localparam int CFG_NAMES   = 6;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int NAME_BITS   = 8 * NAME_BYTES;
    localparam int LEN_W       = $clog2(NAME_BYTES + 2);
    localparam int ACC_W       = MANTISSA_BITS - 1;
    localparam int IDX_W       = 3;
    localparam int COUNT_W     = 3;
    localparam int FRAC_W      = 6;
    localparam int MANT_OUT_W  = 32;
    localparam int OUT_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_0     = 3'd1;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [ACC_W-1:0]  ACC_MAX     = {ACC_W{1'b1}};
    localparam logic [FRAC_W-1:0] FRAC_MAX    = {FRAC_W{1'b1}};

    typedef enum logic [1:0]
    {
        PH_NAME  = 2'd0,
        PH_VALUE = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef logic [NAME_BITS-1:0] name_word_t;
    typedef name_word_t name_array_t [CFG_NAMES];

    typedef struct packed
    {
        logic             found;
        logic [IDX_W-1:0] index;
    } match_t;

endpackage

`default_nettype wire

[rtl/named_decimal_assignment_parser.sv]
// Top level: byte-stream name=value parser with configurable name table.
//
//  channel  | direction | tdata (low bit up)                             | tlast
//  s_axis   | in        | rx_byte[7:0]                                   | end_of_message
//  m_axis   | out       | found, name_index, mantissa, fraction_digits,  | -
//           |           | overflow, bad_character, zero pad to 48        |
//  cfg      | in        | cfg_we / cfg_index / cfg_data, no read-back    | -
//
// One byte per cycle sustained while no result is stalled; a byte passes the
// input register, then the parse update and result register, so a result is
// registered when the request carrying end_of_message leaves the input
// register. Reset clears the parse state and names. A stalled result holds
// while the input register keeps taking one more byte.
`default_nettype none

module named_decimal_assignment_parser
    import ndap_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // rx_byte
    input  wire logic                  s_axis_tlast,   // end_of_message
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // found, name_index[3], mantissa[32], fraction_digits[6], overflow, bad_character
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    logic [COUNT_W-1:0] name_count_reg;
    name_array_t        names_reg;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eom_reg;
    logic       advance;

    phase_t             phase_reg, phase_next;
    name_word_t         shift_reg, shift_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               mfound_reg, mfound_next;
    logic [IDX_W-1:0]   midx_reg, midx_next;
    logic               neg_reg, neg_next;
    logic               first_reg, first_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               dot_reg, dot_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               ovf_reg, ovf_next;
    logic               bad_reg, bad_next;

    logic                  out_vld_reg;
    logic                  o_found_reg;
    logic [IDX_W-1:0]      o_idx_reg;
    logic [MANT_OUT_W-1:0] o_mant_reg;
    logic [FRAC_W-1:0]     o_frac_reg;
    logic                  o_ovf_reg;
    logic                  o_bad_reg;

    match_t                  match;
    logic                    match_now;
    logic                    is_digit;
    logic [ACC_W+3:0]        acc_times;
    logic [MANTISSA_BITS-1:0] mant_signed;
    logic [63:0]             mant_wide;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_count_reg <= '0;
            for (int i = 0; i < CFG_NAMES; i++)
            begin
                names_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_NAME_COUNT)
            begin
                name_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < CFG_NAMES; i++)
            begin
                if (cfg_index == REG_NAME_0 + CFG_IDX_W'(i))
                begin
                    names_reg[i] <= cfg_data[NAME_BITS-1:0];
                end
            end
        end
    end

    // input register
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eom_reg  <= s_axis_tlast;
        end
    end

    ndap_name_match u_match
    (
        .names       (names_reg),
        .name_count  (name_count_reg),
        .name_shift  (shift_next),
        .name_length (len_next),
        .result      (match)
    );

    assign is_digit  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_ZERO + 8'd9);
    assign acc_times = ((ACC_W+4)'(acc_reg) << 3) + ((ACC_W+4)'(acc_reg) << 1)
                     + (ACC_W+4)'(in_byte_reg[3:0]);
    assign match_now = (phase_reg == PH_NAME)
                    && ((in_byte_reg == CH_EQUALS) || (in_byte_reg == CH_NUL) || in_eom_reg);

    // parse state update
    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        acc_next   = acc_reg;
        dot_next   = dot_reg;
        frac_next  = frac_reg;
        ovf_next   = ovf_reg;
        bad_next   = bad_reg;
        unique case (phase_reg)
            PH_NAME:
            begin
                if (in_byte_reg == CH_EQUALS)
                begin
                    phase_next = PH_VALUE;
                end
                else if (in_byte_reg == CH_NUL)
                begin
                    phase_next = PH_DONE;
                end
                else if (len_reg < LEN_W'(NAME_BYTES))
                begin
                    for (int k = 0; k < NAME_BYTES; k++)
                    begin
                        if (len_reg == LEN_W'(k))
                        begin
                            shift_next[8*k +: 8] = in_byte_reg;
                        end
                    end
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    len_next = LEN_W'(NAME_BYTES + 1);
                end
            end
            PH_VALUE:
            begin
                first_next = 1'b0;
                if ((in_byte_reg == CH_HASH) || (in_byte_reg == CH_NUL))
                begin
                    phase_next = PH_DONE;
                end
                else if ((in_byte_reg == CH_MINUS) && first_reg)
                begin
                    neg_next = 1'b1;
                end
                else if (in_byte_reg == CH_DOT)
                begin
                    dot_next  = 1'b1;
                    frac_next = '0;
                end
                else if (is_digit)
                begin
                    if (acc_times > (ACC_W+4)'(ACC_MAX))
                    begin
                        acc_next = ACC_MAX;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_times[ACC_W-1:0];
                    end
                    if (dot_reg && (frac_reg != FRAC_MAX))
                    begin
                        frac_next = frac_reg + FRAC_W'(1);
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // match outputs
    always_comb
    begin
        mfound_next = match_now ? match.found : mfound_reg;
        midx_next   = match_now ? match.index : midx_reg;
    end

    assign mant_signed = neg_next ? (MANTISSA_BITS'(0) - MANTISSA_BITS'(acc_next))
                                  : MANTISSA_BITS'(acc_next);
    assign mant_wide   = 64'(mant_signed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NAME;
            shift_reg  <= '0;
            len_reg    <= '0;
            mfound_reg <= 1'b0;
            midx_reg   <= '0;
            neg_reg    <= 1'b0;
            first_reg  <= 1'b1;
            acc_reg    <= '0;
            dot_reg    <= 1'b0;
            frac_reg   <= '0;
            ovf_reg    <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (in_eom_reg)
            begin
                phase_reg  <= PH_NAME;
                shift_reg  <= '0;
                len_reg    <= '0;
                mfound_reg <= 1'b0;
                midx_reg   <= '0;
                neg_reg    <= 1'b0;
                first_reg  <= 1'b1;
                acc_reg    <= '0;
                dot_reg    <= 1'b0;
                frac_reg   <= '0;
                ovf_reg    <= 1'b0;
                bad_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                shift_reg  <= shift_next;
                len_reg    <= len_next;
                mfound_reg <= mfound_next;
                midx_reg   <= midx_next;
                neg_reg    <= neg_next;
                first_reg  <= first_next;
                acc_reg    <= acc_next;
                dot_reg    <= dot_next;
                frac_reg   <= frac_next;
                ovf_reg    <= ovf_next;
                bad_reg    <= bad_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_eom_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_eom_reg)
        begin
            o_found_reg <= mfound_next;
            o_idx_reg   <= mfound_next ? midx_next : '0;
            o_mant_reg  <= mfound_next ? mant_wide[MANT_OUT_W-1:0] : '0;
            o_frac_reg  <= mfound_next ? frac_next : '0;
            o_ovf_reg   <= mfound_next && ovf_next;
            o_bad_reg   <= mfound_next && bad_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, o_bad_reg, o_ovf_reg, o_frac_reg, o_mant_reg,
                            o_idx_reg, o_found_reg};

    // checks
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !o_found_reg) |->
            (o_idx_reg == '0) && (o_mant_reg == '0) && (o_frac_reg == '0)
            && !o_ovf_reg && !o_bad_reg)
        else $error("result without match carries non-zero fields");

    a_clear_after_eom: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eom_reg) |=>
            (phase_reg == PH_NAME) && (len_reg == '0) && first_reg && (acc_reg == '0))
        else $error("parse state not cleared after end of message");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> in_vld_reg && $stable(in_byte_reg)
            && $stable(in_eom_reg))
        else $error("input register lost a pending request");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && (phase_reg != PH_NAME)) |-> (acc_reg == ACC_MAX))
        else $error("overflow flagged but accumulator not saturated");

endmodule

`default_nettype wire

[rtl/ndap_name_match.sv]
// Compares the collected name against the configured name table.
`default_nettype none

module ndap_name_match
    import ndap_pkg::*;
(
    input  wire name_array_t        names,
    input  wire logic [COUNT_W-1:0] name_count,
    input  wire name_word_t         name_shift,
    input  wire logic [LEN_W-1:0]   name_length,
    output match_t                  result
);

    logic [COUNT_W-1:0]    count_clamped;
    logic [NAME_SLOTS-1:0] slot_hit;

    assign count_clamped = (name_count > COUNT_W'(NAME_SLOTS)) ? COUNT_W'(NAME_SLOTS)
                                                                : name_count;

    always_comb
    begin
        for (int i = 0; i < NAME_SLOTS; i++)
        begin
            slot_hit[i] = (name_length <= LEN_W'(NAME_BYTES)) && (COUNT_W'(i) < count_clamped);
            for (int k = 0; k < NAME_BYTES; k++)
            begin
                if (LEN_W'(k) < name_length)
                begin
                    if (names[i][8*k +: 8] != name_shift[8*k +: 8])
                    begin
                        slot_hit[i] = 1'b0;
                    end
                end
                else if (LEN_W'(k) == name_length)
                begin
                    if (names[i][8*k +: 8] != CH_NUL)
                    begin
                        slot_hit[i] = 1'b0;
                    end
                end
            end
        end
    end

    // lowest index wins
    always_comb
    begin
        result = '0;
        for (int i = NAME_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_hit[i])
            begin
                result.found = 1'b1;
                result.index = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire
